@@ rtl/cpspl_pkg.sv @@
// Shared types and constants for the command frame to CAN packet splitter.
// No dependencies; every other file in rtl/ imports this package.
package cpspl_pkg;

	// Byte appended after the parameters of a frame's last packet.
	localparam logic [7:0] END_MARK = 8'h6B;

	// Fixed result field widths.
	localparam int unsigned ID_W      = 16;
	localparam int unsigned LEN_W     = 4;
	localparam int unsigned PAYLOAD_W = 64;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned PAY_BYTES = PAYLOAD_W / 8;

	// Result status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MANY  = 2'd2;

	// Frame parser phases.
	typedef enum logic [1:0] {
		PH_ADDR,
		PH_FUNC,
		PH_PARAM,
		PH_DROP
	} phase_t;

	// One result item as it travels from the frame control to the output register.
	typedef struct packed {
		logic [ID_W-1:0]      id;
		logic [LEN_W-1:0]     length;
		logic [PAYLOAD_W-1:0] payload;
		logic                 final_pkt;
		logic [STATUS_W-1:0]  status;
	} result_t;

endpackage

@@ rtl/cpspl_frame_ctl.sv @@
// Frame parser and packet builder: phase FSM, held address/function,
// pending parameter buffer and packet counter. Depends on cpspl_pkg.
module cpspl_frame_ctl import cpspl_pkg::*; #(
	parameter int unsigned PKT_LIMIT         = 16,
	parameter int unsigned PARAMS_PER_PACKET = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] item_byte,
	input  logic       item_end,
	output logic       has_result,
	output result_t    result
);

	localparam int unsigned CNT_W = $clog2(PARAMS_PER_PACKET + 1);
	localparam int unsigned PN_W  = $clog2(PKT_LIMIT + 1);

	phase_t              phase_q, phase_d;
	logic [7:0]          addr_q;
	logic [7:0]          func_q;
	logic [7:0]          param_q [PARAMS_PER_PACKET];
	logic [CNT_W-1:0]    cnt_q;
	logic [PN_W-1:0]     pn_q;

	logic                   pn_full;
	logic                   buf_full;
	logic [PAYLOAD_W-1:0]   pk_payload;
	logic [LEN_W-1:0]       pk_length;
	logic [LEN_W-1:0]       end_pos;
	logic                   load_addr;
	logic                   load_func;
	logic                   push_param;
	logic                   restart_param;
	logic                   pn_inc;

	assign pn_full  = (pn_q >= PN_W'(PKT_LIMIT));
	assign buf_full = (cnt_q >= CNT_W'(PARAMS_PER_PACKET));
	assign end_pos  = LEN_W'(cnt_q) + LEN_W'(1);

	// Pack function code, pending parameters and, on the last packet, the end mark.
	always_comb begin
		pk_payload      = '0;
		pk_payload[7:0] = func_q;
		for (int i = 0; i < PARAMS_PER_PACKET; i++) begin
			if (CNT_W'(i) < cnt_q) begin
				pk_payload[8*i+8 +: 8] = param_q[i];
			end
		end
		for (int k = 1; k < PAY_BYTES; k++) begin
			if (item_end && (LEN_W'(k) == end_pos)) begin
				pk_payload[8*k +: 8] = END_MARK;
			end
		end
		pk_length = LEN_W'(1) + LEN_W'(cnt_q) + LEN_W'(item_end);
	end

	// Next phase.
	always_comb begin
		phase_d = phase_q;
		unique case (phase_q)
			PH_ADDR: begin
				if (!item_end) phase_d = PH_FUNC;
			end
			PH_FUNC: begin
				phase_d = item_end ? PH_ADDR : PH_PARAM;
			end
			PH_PARAM: begin
				if (item_end) begin
					phase_d = PH_ADDR;
				end else if (buf_full && pn_full) begin
					phase_d = PH_DROP;
				end
			end
			PH_DROP: begin
				if (item_end) phase_d = PH_ADDR;
			end
			default: phase_d = PH_ADDR;
		endcase
	end

	// Result and buffer update strobes.
	always_comb begin
		has_result    = 1'b0;
		result        = '0;
		load_addr     = 1'b0;
		load_func     = 1'b0;
		push_param    = 1'b0;
		restart_param = 1'b0;
		pn_inc        = 1'b0;
		unique case (phase_q)
			PH_ADDR, PH_FUNC: begin
				if (item_end) begin
					has_result       = 1'b1;
					result.final_pkt = 1'b1;
					result.status    = ST_SHORT;
				end else begin
					load_addr = (phase_q == PH_ADDR);
					load_func = (phase_q == PH_FUNC);
				end
			end
			PH_PARAM: begin
				if (item_end || buf_full) begin
					has_result = 1'b1;
					if (pn_full) begin
						result.final_pkt = 1'b1;
						result.status    = ST_MANY;
					end else begin
						result.id        = {addr_q, 8'(pn_q)};
						result.length    = pk_length;
						result.payload   = pk_payload;
						result.final_pkt = item_end;
						result.status    = ST_OK;
						pn_inc           = 1'b1;
						restart_param    = !item_end;
					end
				end else begin
					push_param = 1'b1;
				end
			end
			PH_DROP: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ADDR;
			addr_q  <= '0;
			func_q  <= '0;
			cnt_q   <= '0;
			pn_q    <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			if (load_addr) addr_q <= item_byte;
			if (load_func) begin
				func_q <= item_byte;
				cnt_q  <= '0;
				pn_q   <= '0;
			end
			if (push_param)    cnt_q <= cnt_q + CNT_W'(1);
			if (restart_param) cnt_q <= CNT_W'(1);
			if (pn_inc)        pn_q  <= pn_q + PN_W'(1);
		end
	end

	// Parameter buffer: no reset, only entries below the count are ever read.
	always_ff @(posedge clk) begin
		for (int i = 0; i < PARAMS_PER_PACKET; i++) begin
			if (step && ((push_param && (cnt_q == CNT_W'(i))) || (restart_param && (i == 0)))) begin
				param_q[i] <= item_byte;
			end
		end
	end

endmodule

@@ rtl/cpspl_out_reg.sv @@
// Result register with valid/stall handshake toward the packet consumer.
// Depends on cpspl_pkg for the result struct.
module cpspl_out_reg import cpspl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t load_data,
	input  logic    out_stall,
	output logic    out_free,
	output logic    out_valid,
	output result_t out_data
);

	logic    valid_q;
	result_t data_q;

	// Free when empty or draining this cycle.
	assign out_free  = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= load_data;
	end

endmodule

@@ rtl/command_frame_to_can_packet_splitter_core.sv @@
// Top level of the command frame to CAN packet splitter: input stage,
// frame control and result register. Depends on cpspl_pkg, cpspl_frame_ctl, cpspl_out_reg.
//
// chan | handshake           | fields
// in   | in_valid/in_stall   | frame_byte frame_end
// out  | out_valid/out_stall | packet_id packet_length packet_payload final_packet split_status
//
// One frame byte per cycle sustained while the output does not stall; a byte that
// produces a packet is registered in the input stage and then loads the result
// register, from which the packet transfers out (input stage, then result register).
// Throughput is set by the update of the frame control state for each staged byte.
// Reset (arst_n low) returns the parser to expecting an address byte, packet
// count and buffered parameter count to zero, and empties both stages.
// A stall on the output holds the result register; the input stage then holds
// a byte that needs a result and raises in_stall until the result can move.
module command_frame_to_can_packet_splitter_core import cpspl_pkg::*; #(
	parameter int unsigned PKT_LIMIT         = 16,
	parameter int unsigned PARAMS_PER_PACKET = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           frame_byte,
	input  logic                 frame_end,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [ID_W-1:0]      packet_id,
	output logic [LEN_W-1:0]     packet_length,
	output logic [PAYLOAD_W-1:0] packet_payload,
	output logic                 final_packet,
	output logic [STATUS_W-1:0]  split_status
);

	// Input stage.
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;

	logic    in_take;
	logic    step;
	logic    has_result;
	logic    out_free;
	result_t result;
	result_t out_data;

	// Advance the staged byte when it makes no result or the result register can
	// take the new packet this cycle.
	assign step     = valid_s1 && (!has_result || out_free);
	// Hold off the producer only while the staged byte cannot advance.
	assign in_stall = valid_s1 && !step;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload of the input stage needs no reset.
	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= frame_byte;
			end_s1  <= frame_end;
		end
	end

	cpspl_frame_ctl #(
		.PKT_LIMIT         (PKT_LIMIT),
		.PARAMS_PER_PACKET (PARAMS_PER_PACKET)
	) u_frame_ctl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.item_byte  (byte_s1),
		.item_end   (end_s1),
		.has_result (has_result),
		.result     (result)
	);

	cpspl_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (step && has_result),
		.load_data (result),
		.out_stall (out_stall),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign packet_id      = out_data.id;
	assign packet_length  = out_data.length;
	assign packet_payload = out_data.payload;
	assign final_packet   = out_data.final_pkt;
	assign split_status   = out_data.status;

`ifndef NO_ASSERTIONS
	// Error results carry final set and no packet content.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (split_status != ST_OK) |->
			final_packet && (packet_length == '0) && (packet_id == '0) &&
			(packet_payload == '0))
		else $error("error result carries packet content");

	// A packet that is not the last one is always full.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (split_status == ST_OK) && !final_packet |->
			(packet_length == LEN_W'(PARAMS_PER_PACKET + 1)))
		else $error("intermediate packet is not full");

	// A good last packet ends with the end mark.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (split_status == ST_OK) && final_packet |->
			(packet_length >= LEN_W'(2)) &&
			(packet_payload[8*(packet_length-1) +: 8] == END_MARK))
		else $error("last packet lacks end mark");

	// The input side is only held while a byte waits in the input stage.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && has_result && out_valid && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule

@@ tb/cpspl_packet_checker.sv @@
// Packet checker for the command frame to CAN packet splitter: predicts packets from
// byte transfers and compares them with packet transfers. Depends on cpspl_pkg.
module cpspl_packet_checker import cpspl_pkg::*; #(
	parameter int unsigned PKT_LIMIT         = 16,
	parameter int unsigned PARAMS_PER_PACKET = 6
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [7:0]           frame_byte,
	input  logic                 frame_end,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [ID_W-1:0]      packet_id,
	input  logic [LEN_W-1:0]     packet_length,
	input  logic [PAYLOAD_W-1:0] packet_payload,
	input  logic                 final_packet,
	input  logic [STATUS_W-1:0]  split_status,
	output int                   mismatch_count,
	output int                   packets_waiting,
	output int                   packets_checked,
	output int                   overflow_seen
);

	// Predicted splitter state.
	phase_t     cur_phase;
	logic [7:0] cur_address;
	logic [7:0] cur_function;
	logic [7:0] param_buf [PARAMS_PER_PACKET];
	int         param_fill;
	int         packet_seq;

	result_t    expected_packets [$];
	result_t    oldest;

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH packet %0d: %s got %h want %h", packets_checked, what, got, want);
		mismatch_count++;
	endtask

	task automatic expect_error(input logic [STATUS_W-1:0] code);
		result_t r;
		r = '0;
		r.final_pkt = 1'b1;
		r.status    = code;
		expected_packets.push_back(r);
	endtask

	// Build the packet from the held function and parameters; refuse past the limit.
	task automatic expect_packet(input bit last, output bit sent);
		result_t r;
		int      len;
		r = '0;
		if (packet_seq >= PKT_LIMIT) begin
			expect_error(ST_MANY);
			sent = 1'b0;
		end else begin
			r.payload[7:0] = cur_function;
			len = 1;
			for (int i = 0; i < param_fill; i++) begin
				r.payload[8*len +: 8] = param_buf[i];
				len++;
			end
			if (last) begin
				r.payload[8*len +: 8] = END_MARK;
				len++;
			end
			r.id        = {cur_address, packet_seq[7:0]};
			r.length    = len[LEN_W-1:0];
			r.final_pkt = last;
			r.status    = ST_OK;
			expected_packets.push_back(r);
			packet_seq++;
			sent = 1'b1;
		end
	endtask

	task automatic split_byte(input logic [7:0] b, input logic e);
		bit sent;
		case (cur_phase)
			PH_ADDR: begin
				if (e) begin
					expect_error(ST_SHORT);
				end else begin
					cur_address = b;
					cur_phase   = PH_FUNC;
				end
			end
			PH_FUNC: begin
				if (e) begin
					cur_phase = PH_ADDR;
					expect_error(ST_SHORT);
				end else begin
					cur_function = b;
					param_fill   = 0;
					packet_seq   = 0;
					cur_phase    = PH_PARAM;
				end
			end
			PH_PARAM: begin
				if (e) begin
					cur_phase = PH_ADDR;
					expect_packet(1'b1, sent);
				end else if (param_fill >= PARAMS_PER_PACKET) begin
					// a seventh parameter releases the held full packet
					expect_packet(1'b0, sent);
					if (!sent) begin
						cur_phase = PH_DROP;
					end else begin
						param_buf[0] = b;
						param_fill   = 1;
					end
				end else begin
					param_buf[param_fill] = b;
					param_fill++;
				end
			end
			default: begin
				if (e)
					cur_phase = PH_ADDR;
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_phase    = PH_ADDR;
			cur_address  = '0;
			cur_function = '0;
			param_fill   = 0;
			packet_seq   = 0;
			mismatch_count  = 0;
			packets_checked = 0;
			overflow_seen   = 0;
			expected_packets.delete();
			packets_waiting <= 0;
		end else begin
			// check the packet transfer first; it never stems from this edge's byte
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if (split_status === ST_MANY)
					overflow_seen++;
				if (expected_packets.size() == 0) begin
					report_mismatch("packet with none expected", 64'(packet_id), 64'(0));
				end else begin
					oldest = expected_packets.pop_front();
					if (packet_id !== oldest.id)
						report_mismatch("packet_id", 64'(packet_id), 64'(oldest.id));
					if (packet_length !== oldest.length)
						report_mismatch("packet_length", 64'(packet_length),
							64'(oldest.length));
					if (packet_payload !== oldest.payload)
						report_mismatch("packet_payload", packet_payload, oldest.payload);
					if (final_packet !== oldest.final_pkt)
						report_mismatch("final_packet", 64'(final_packet),
							64'(oldest.final_pkt));
					if (split_status !== oldest.status)
						report_mismatch("split_status", 64'(split_status),
							64'(oldest.status));
				end
				packets_checked++;
			end
			if (in_valid === 1'b1 && in_stall === 1'b0)
				split_byte(frame_byte, frame_end);
			packets_waiting <= expected_packets.size();
		end
	end

endmodule

@@ tb/tb.sv @@
// Testbench top for the command frame to CAN packet splitter: clock, reset, byte
// stimulus and output stalls. Depends on cpspl_pkg, the core and cpspl_packet_checker.
module tb;
	import cpspl_pkg::*;

	localparam int unsigned PKT_LIMIT         = 16;
	localparam int unsigned PARAMS_PER_PACKET = 6;
	localparam int          RANDOM_BYTES      = 1150;
	// Two register stages between a byte transfer and its packet; pad it.
	localparam int          SETTLE_CYCLES     = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           frame_byte = 8'h00;
	logic                 frame_end = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ID_W-1:0]      packet_id;
	logic [LEN_W-1:0]     packet_length;
	logic [PAYLOAD_W-1:0] packet_payload;
	logic                 final_packet;
	logic [STATUS_W-1:0]  split_status;

	int mismatch_count;
	int packets_waiting;
	int packets_checked;
	int overflow_seen;

	// Sender pacing and run bookkeeping.
	int burst_left = 0;
	int bytes_sent = 0;
	int frames_sent = 0;

	command_frame_to_can_packet_splitter_core #(
		.PKT_LIMIT         (PKT_LIMIT),
		.PARAMS_PER_PACKET (PARAMS_PER_PACKET)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_byte     (frame_byte),
		.frame_end      (frame_end),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.packet_id      (packet_id),
		.packet_length  (packet_length),
		.packet_payload (packet_payload),
		.final_packet   (final_packet),
		.split_status   (split_status)
	);

	cpspl_packet_checker #(
		.PKT_LIMIT         (PKT_LIMIT),
		.PARAMS_PER_PACKET (PARAMS_PER_PACKET)
	) checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.frame_byte      (frame_byte),
		.frame_end       (frame_end),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.packet_id       (packet_id),
		.packet_length   (packet_length),
		.packet_payload  (packet_payload),
		.final_packet    (final_packet),
		.split_status    (split_status),
		.mismatch_count  (mismatch_count),
		.packets_waiting (packets_waiting),
		.packets_checked (packets_checked),
		.overflow_seen   (overflow_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: switch between stall styles each time stall_tick wraps so that stalls land
	// on every phase of the frame, with some stretches of no stall at all.
	logic [7:0] stall_tick = 8'd0;
	int         stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_tick <= 8'd0;
		end else begin
			stall_tick <= stall_tick + 8'd1;
			if (stall_tick == 8'd255)
				stall_mode = $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= stall_tick[2];
			endcase
		end
	end

	// Hold one byte on the channel until its transfer; idle between bursts.
	task automatic send_byte(input logic [7:0] b, input logic e);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 40);
		end
		in_valid   <= 1'b1;
		frame_byte <= b;
		frame_end  <= e;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Send a well-formed frame: address, function, parameters, end byte.
	task automatic send_frame(input int n_params);
		send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b0);
		repeat (n_params) send_byte(8'($urandom), 1'b0);
		send_byte(8'($urandom), 1'b1);
		frames_sent++;
	endtask

	// Drop valid and wait until every predicted packet has come out.
	task automatic drain_packets();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (packets_waiting != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int kind;
		int frame_idx;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: end mark on the address byte gives a too-short status.
		send_byte(8'hFF, 1'b1);
		// End mark on the function byte is also too short.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// No parameters: payload is function plus end marker.
		send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		// Exactly six parameters fill all eight payload bytes in one packet.
		send_byte(8'h5A, 1'b0);
		send_byte(8'hFF, 1'b0);
		for (int i = 0; i < 6; i++)
			send_byte((i % 2) ? 8'h00 : 8'hFF, 1'b0);
		send_byte(8'hA5, 1'b1);
		// Seven parameters: the seventh releases the first full packet.
		send_byte(8'h01, 1'b0);
		send_byte(8'h33, 1'b0);
		for (int i = 0; i < 7; i++)
			send_byte(8'(8'h10 + i), 1'b0);
		send_byte(8'hFF, 1'b1);
		frames_sent += 5;

		// Pause the sender until all packets so far have been checked.
		drain_packets();

		// Packet limit: overflow mid-frame (then drop), overflow on the end byte,
		// and a frame that just fits the limit.
		send_frame(PKT_LIMIT * PARAMS_PER_PACKET + 7);
		send_frame(PKT_LIMIT * PARAMS_PER_PACKET + 2);
		send_frame(PKT_LIMIT * PARAMS_PER_PACKET);

		frame_idx = 0;
		while (bytes_sent < RANDOM_BYTES + 25) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				send_frame($urandom_range(0, 20));
			end else if (kind < 78) begin
				// long frames straddle the packet limit
				send_frame($urandom_range(PKT_LIMIT * PARAMS_PER_PACKET - 2,
					PKT_LIMIT * PARAMS_PER_PACKET + 18));
			end else if (kind < 88) begin
				// too-short frames
				if ($urandom_range(0, 1))
					send_byte(8'($urandom), 1'b0);
				send_byte(8'($urandom), 1'b1);
				frames_sent++;
			end else begin
				// noise: random bytes with random end marks
				repeat ($urandom_range(1, 8))
					send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end
			frame_idx++;
			if (frame_idx == 20)
				drain_packets();
		end

		drain_packets();

		$display("Run covered %0d frames in %0d byte transfers; %0d packets checked, %0d overflows.",
			frames_sent, bytes_sent, packets_checked, overflow_seen);
		if (packets_waiting != 0)
			$display("%0d expected packets never arrived", packets_waiting);
		if (mismatch_count == 0 && packets_waiting == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#4000000;
		$display("Timeout waiting for transfers");
		$display("*** FAILED ***");
		$finish;
	end

endmodule

@@ command_frame_to_can_packet_splitter_core.f @@
rtl/cpspl_pkg.sv
rtl/cpspl_frame_ctl.sv
rtl/cpspl_out_reg.sv
rtl/command_frame_to_can_packet_splitter_core.sv
tb/cpspl_packet_checker.sv
tb/tb.sv
